@@ design/flic_byte_run_decode_core_defines.svh @@
// Assertion macros shared by the byte-run decoder RTL.
// Define ASSERT_OFF to compile the checks out; uses clk and rst_n of the module.
`ifndef FLIC_BYTE_RUN_DECODE_CORE_DEFINES_SVH
`define FLIC_BYTE_RUN_DECODE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("check failed");
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ design/flic_brun_pkg.sv @@
// Types and constants for the byte-run chunk decoder.
// No dependencies; imported by every module of the decoder.
`timescale 1ns / 1ps
package flic_brun_pkg;

    localparam int CFG_W   = 11;
    localparam int ADDR_W  = 22;
    localparam int COL_W   = 12;
    localparam int LEN_W   = 7;
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_BITMAP_WIDTH = 2'd2;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd320;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd200;
    localparam logic [CFG_W-1:0] RST_BITMAP_WIDTH = 11'd320;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_COUNT   = 4'b0010,
        PH_FILL    = 4'b0100,
        PH_LITERAL = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [CFG_W-1:0] frame_width;
        logic [CFG_W-1:0] frame_height;
        logic [CFG_W-1:0] bitmap_width;
    } cfg_t;

    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] pixel_address;
        logic [BYTE_W-1:0] pixel_value;
        logic [LEN_W-1:0]  run_length;
        logic              frame_done;
    } result_t;

endpackage

@@ design/flic_byte_run_decode_core.sv @@
//  channel  | dir | handshake        | payload
//  s_axis   | in  | s_tvalid/tready  | tdata[7:0] data_byte, tuser frame_start
//  m_axis   | out | m_tvalid/tready  | tdata address/value/run_length, tlast frame_done
//  cfg      | in  | cfg_we           | cfg_addr index, cfg_wdata value
// One compressed byte per cycle while the output is not held: an accepted byte is decoded
// from the input register (stride multiplier, column compare, state update) and its write command,
// if any, loads the output register, which drives m_tvalid.
// rst_n clears the decode state to idle and loads the register defaults.
// A held output transaction stops decode; s_tready drops once a byte waits behind it.
// Top level of the byte-run chunk decoder.
// Depends on flic_brun_pkg, flic_brun_cfg, flic_brun_step and the defines header.
`timescale 1ns / 1ps
`include "flic_byte_run_decode_core_defines.svh"
module flic_byte_run_decode_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] data_byte
    input  logic                             s_tuser,   // [0] frame_start
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [21:0] pixel_address, [29:22] pixel_value, [36:30] run_length, [39:37] zero
    output logic [39:0]                      m_tdata,
    output logic                             m_tlast,   // frame_done
    input  logic                             cfg_we,
    input  logic [flic_brun_pkg::IDX_W-1:0]  cfg_addr,
    input  logic [flic_brun_pkg::CFG_W-1:0]  cfg_wdata
);
    import flic_brun_pkg::*;

    cfg_t              cfg;
    result_t           res;
    logic              in_vld_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_start_reg;
    logic              adv;
    logic              out_vld_reg;
    result_t           out_reg;

    flic_brun_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    flic_brun_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .step_en     (adv),
        .data_byte   (in_byte_reg),
        .frame_start (in_start_reg),
        .res         (res)
    );

    assign adv      = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv && res.vld)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && res.vld)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'b000, out_reg.run_length, out_reg.pixel_value, out_reg.pixel_address};
    assign m_tlast  = out_reg.frame_done;

    `ASSERT_IMPLY(a_len_nonzero, m_tvalid, m_tdata[36:30] != 7'd0)
    `ASSERT_IMPLY(a_ready_blocked, !s_tready, in_vld_reg && out_vld_reg && !m_tready)
    `ASSERT_NEXT(a_no_drop, out_vld_reg && !m_tready, out_vld_reg && $stable(out_reg))
    `ASSERT_NEXT(a_load, adv && res.vld, m_tvalid)

endmodule

@@ design/flic_brun_cfg.sv @@
// Configuration registers of the byte-run decoder, saturated to the size limits.
// Depends on flic_brun_pkg.
`timescale 1ns / 1ps
module flic_brun_cfg #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [flic_brun_pkg::IDX_W-1:0]     cfg_addr,
    input  logic [flic_brun_pkg::CFG_W-1:0]     cfg_wdata,
    output flic_brun_pkg::cfg_t                 cfg
);
    import flic_brun_pkg::*;

    localparam logic [CFG_W+1:0] W_LIM = (CFG_W+2)'(MAX_WIDTH - 1);
    localparam logic [CFG_W+1:0] H_LIM = (CFG_W+2)'(MAX_HEIGHT - 1);

    cfg_t             cfg_reg;
    logic [CFG_W-1:0] w_sat;
    logic [CFG_W-1:0] h_sat;

    always_comb
    begin
        w_sat = ({2'b00, cfg_wdata} > W_LIM) ? W_LIM[CFG_W-1:0] : cfg_wdata;
        h_sat = ({2'b00, cfg_wdata} > H_LIM) ? H_LIM[CFG_W-1:0] : cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= RST_FRAME_WIDTH;
            cfg_reg.frame_height <= RST_FRAME_HEIGHT;
            cfg_reg.bitmap_width <= RST_BITMAP_WIDTH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_FRAME_WIDTH:  cfg_reg.frame_width  <= w_sat;
                CFG_FRAME_HEIGHT: cfg_reg.frame_height <= h_sat;
                CFG_BITMAP_WIDTH: cfg_reg.bitmap_width <= w_sat;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/flic_brun_step.sv @@
// Decode state of the byte-run decoder and its per-byte next-state logic.
// Depends on flic_brun_pkg.
`timescale 1ns / 1ps
module flic_brun_step (
    input  logic                                clk,
    input  logic                                rst_n,
    input  flic_brun_pkg::cfg_t                 cfg,
    input  logic                                step_en,
    input  logic [flic_brun_pkg::BYTE_W-1:0]    data_byte,
    input  logic                                frame_start,
    output flic_brun_pkg::result_t              res
);
    import flic_brun_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [ADDR_W-1:0] row_base_reg, row_base_next;
    logic [COL_W-1:0]  column_reg, column_next;
    logic [LEN_W-1:0]  pend_reg, pend_next;
    logic [CFG_W-1:0]  lines_reg, lines_next;
    logic              fin_reg, fin_next;

    logic [CFG_W+1:0]  stride;
    logic [CFG_W-1:0]  height_m1;
    logic [2*CFG_W+1:0] base_prod;

    logic              chk_en;
    logic [COL_W-1:0]  chk_col;
    logic [CFG_W-1:0]  chk_lines;
    logic [ADDR_W-1:0] chk_rb;
    logic [CFG_W-1:0]  lines_dec;
    logic              chk_done;

    always_comb
    begin
        stride    = ({2'b00, cfg.bitmap_width} + (CFG_W+2)'(3)) & ~(CFG_W+2)'(3);
        height_m1 = cfg.frame_height - CFG_W'(1);
        base_prod = (2*CFG_W+2)'(stride) * (2*CFG_W+2)'(height_m1);
    end

    always_comb
    begin
        phase_next    = phase_reg;
        row_base_next = row_base_reg;
        column_next   = column_reg;
        pend_next     = pend_reg;
        lines_next    = lines_reg;
        fin_next      = fin_reg;
        chk_en        = 1'b0;
        chk_col       = column_reg;
        chk_lines     = lines_reg;
        chk_rb        = row_base_reg;
        chk_done      = 1'b0;
        lines_dec     = '0;
        res           = '0;
        res.pixel_address = row_base_reg + ADDR_W'(column_reg);
        res.pixel_value   = data_byte;

        if (frame_start)
        begin
            fin_next    = 1'b0;
            column_next = '0;
            pend_next   = '0;
            lines_next  = cfg.frame_height;
            if (cfg.frame_height == '0)
            begin
                fin_next      = 1'b1;
                phase_next    = PH_HEADER;
                row_base_next = '0;
            end
            else
            begin
                chk_en    = 1'b1;
                chk_col   = '0;
                chk_lines = cfg.frame_height;
                chk_rb    = base_prod[ADDR_W-1:0];
            end
        end
        else if (!fin_reg)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    chk_en = 1'b1;
                end
                PH_COUNT:
                begin
                    if (data_byte[7])
                    begin
                        pend_next  = ~data_byte[LEN_W-1:0];
                        phase_next = PH_LITERAL;
                    end
                    else
                    begin
                        pend_next  = data_byte[LEN_W-1:0];
                        phase_next = PH_FILL;
                    end
                end
                PH_FILL:
                begin
                    chk_en = 1'b1;
                    if (pend_reg != '0)
                    begin
                        res.vld        = 1'b1;
                        res.run_length = pend_reg;
                        chk_col        = column_reg + COL_W'(pend_reg);
                    end
                end
                PH_LITERAL:
                begin
                    res.vld        = 1'b1;
                    res.run_length = LEN_W'(1);
                    column_next    = column_reg + COL_W'(1);
                    if (pend_reg != '0)
                    begin
                        pend_next = pend_reg - LEN_W'(1);
                    end
                    else
                    begin
                        chk_en  = 1'b1;
                        chk_col = column_reg + COL_W'(1);
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end

        // line end check after a header byte or a whole packet
        if (chk_en)
        begin
            row_base_next = chk_rb;
            lines_next    = chk_lines;
            if (chk_col >= COL_W'(cfg.frame_width))
            begin
                lines_dec   = (chk_lines != '0) ? chk_lines - CFG_W'(1) : '0;
                lines_next  = lines_dec;
                column_next = '0;
                phase_next  = PH_HEADER;
                if (lines_dec == '0)
                begin
                    fin_next = 1'b1;
                    chk_done = 1'b1;
                end
                else
                begin
                    row_base_next = chk_rb - ADDR_W'(stride);
                end
            end
            else
            begin
                column_next = chk_col;
                phase_next  = PH_COUNT;
            end
        end
        res.frame_done = chk_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            row_base_reg <= '0;
            column_reg   <= '0;
            pend_reg     <= '0;
            lines_reg    <= '0;
            fin_reg      <= 1'b1;
        end
        else if (step_en)
        begin
            phase_reg    <= phase_next;
            row_base_reg <= row_base_next;
            column_reg   <= column_next;
            pend_reg     <= pend_next;
            lines_reg    <= lines_next;
            fin_reg      <= fin_next;
        end
    end

endmodule

@@ tb/sv/flic_byte_run_decode_core_tb.sv @@
// Self-checking testbench for the byte-run chunk decoder flic_byte_run_decode_core.
// Streams directed and random chunk bytes, predicts write commands, checks them in order.
// Depends on flic_brun_pkg and the decoder RTL.
`timescale 1ns / 1ps
module flic_byte_run_decode_core_tb;
    import flic_brun_pkg::*;

    localparam int MAX_W      = 2048;
    localparam int MAX_H      = 2048;
    localparam int CYCLE_CAP  = 500000;
    localparam int LONG_HOLD  = 400;
    localparam int DRAIN_WAIT = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } chunk_byte_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [7:0]        value;
        logic [LEN_W-1:0]  len;
        logic              done;
    } wr_cmd_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [39:0]       m_tdata;
    logic              m_tlast;
    logic              cfg_we = 1'b0;
    logic [IDX_W-1:0]  cfg_addr = CFG_FRAME_WIDTH;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    chunk_byte_t chunk_bytes[$];
    wr_cmd_t     pending_writes[$];
    chunk_byte_t drv_item;

    int  idle_mode = 0;
    bit  want_long_stall = 1'b0;
    int  src_gap;
    int  snk_gap;
    int  long_left;
    bit  long_used;
    int  items_sent = 0;
    int  bytes_taken = 0;
    int  writes_seen = 0;
    int  frames_seen = 0;
    int  cfg_sets = 0;
    int  err_cnt = 0;
    int  cycle_cnt = 0;

    // decoder model state and registers
    logic [CFG_W-1:0]  img_width  = RST_FRAME_WIDTH;
    logic [CFG_W-1:0]  img_height = RST_FRAME_HEIGHT;
    logic [CFG_W-1:0]  bmp_width  = RST_BITMAP_WIDTH;
    phase_t            dec_phase  = PH_HEADER;
    logic [ADDR_W-1:0] line_base  = '0;
    logic [COL_W-1:0]  col_pos    = '0;
    logic [LEN_W-1:0]  left_cnt   = '0;
    logic [CFG_W-1:0]  lines_todo = '0;
    bit                idle_flag  = 1'b1;

    flic_byte_run_decode_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    function automatic logic [ADDR_W-1:0] row_stride();
        return ({{(ADDR_W-CFG_W){1'b0}}, bmp_width} + 22'd3) & ~22'd3;
    endfunction

    function automatic bit finish_line();
        if (lines_todo != 0)
            lines_todo = lines_todo - 1'b1;
        col_pos = '0;
        dec_phase = PH_HEADER;
        if (lines_todo == 0)
        begin
            idle_flag = 1'b1;
            return 1'b1;
        end
        line_base = line_base - row_stride();
        return 1'b0;
    endfunction

    function automatic bit line_check();
        if (col_pos >= COL_W'(img_width))
            return finish_line();
        dec_phase = PH_COUNT;
        return 1'b0;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input logic start,
                                       output wr_cmd_t cmd);
        bit ignored;
        cmd = '0;
        if (start)
        begin
            idle_flag = 1'b0;
            col_pos = '0;
            left_cnt = '0;
            lines_todo = img_height;
            if (img_height == 0)
            begin
                idle_flag = 1'b1;
                dec_phase = PH_HEADER;
                line_base = '0;
                return 1'b0;
            end
            line_base = row_stride() * ADDR_W'(img_height - 1'b1);
            ignored = line_check();
            return 1'b0;
        end
        if (idle_flag)
            return 1'b0;
        case (dec_phase)
            PH_HEADER:
            begin
                ignored = line_check();
                return 1'b0;
            end
            PH_COUNT:
            begin
                if (b[7])
                begin
                    left_cnt = LEN_W'(8'd255 - b);
                    dec_phase = PH_LITERAL;
                end
                else
                begin
                    left_cnt = b[6:0];
                    dec_phase = PH_FILL;
                end
                return 1'b0;
            end
            PH_FILL:
            begin
                if (left_cnt == 0)
                begin
                    ignored = line_check();
                    return 1'b0;
                end
                cmd.addr = line_base + ADDR_W'(col_pos);
                cmd.value = b;
                cmd.len = left_cnt;
                col_pos = col_pos + COL_W'(left_cnt);
                cmd.done = line_check();
                return 1'b1;
            end
            default:
            begin
                cmd.addr = line_base + ADDR_W'(col_pos);
                cmd.value = b;
                cmd.len = LEN_W'(1);
                col_pos = col_pos + 1'b1;
                if (left_cnt != 0)
                    left_cnt = left_cnt - 1'b1;
                else
                    cmd.done = line_check();
                return 1'b1;
            end
        endcase
    endfunction

    function automatic int gap_odds();
        return (idle_mode == 2) ? 3 : 11;
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic start);
        chunk_byte_t item;
        item.data = b;
        item.start = start;
        chunk_bytes.push_back(item);
        items_sent++;
    endtask

    task automatic queue_line(input int width, input bit first);
        int col;
        int rem;
        int n;
        int lim;
        int pick;
        col = 0;
        queue_byte(8'($urandom_range(0, 255)), first);
        while (col < width)
        begin
            rem = width - col;
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                queue_byte(8'h00, 1'b0);
                queue_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            else if (pick <= 4)
            begin
                n = $urandom_range(1, (rem + 3 > 127) ? 127 : rem + 3);
                queue_byte(8'(n), 1'b0);
                queue_byte(8'($urandom_range(0, 255)), 1'b0);
                col += n;
            end
            else
            begin
                lim = (width > 64) ? 8 : ((rem + 2 > 128) ? 128 : rem + 2);
                n = $urandom_range(1, lim);
                queue_byte(8'(256 - n), 1'b0);
                repeat (n) queue_byte(8'($urandom_range(0, 255)), 1'b0);
                col += n;
            end
        end
    endtask

    task automatic queue_frame(input int width, input int lines);
        for (int i = 0; i < lines; i++)
            queue_line(width, i == 0);
    endtask

    task automatic drain();
        while (chunk_bytes.size() != 0 || s_tvalid || pending_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        logic [CFG_W-1:0] w_cap;
        logic [CFG_W-1:0] h_cap;
        w_cap = CFG_W'(MAX_W - 1);
        h_cap = CFG_W'(MAX_H - 1);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_FRAME_WIDTH:  img_width  = (val > w_cap) ? w_cap : val;
            CFG_FRAME_HEIGHT: img_height = (val > h_cap) ? h_cap : val;
            CFG_BITMAP_WIDTH: bmp_width  = (val > w_cap) ? w_cap : val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(input int fw, input int fh, input int bw);
        write_reg(CFG_FRAME_WIDTH, CFG_W'(fw));
        write_reg(CFG_FRAME_HEIGHT, CFG_W'(fh));
        write_reg(CFG_BITMAP_WIDTH, CFG_W'(bw));
        cfg_sets++;
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
            src_gap <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (src_gap != 0)
            begin
                src_gap <= src_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (chunk_bytes.size() != 0)
            begin
                drv_item = chunk_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= drv_item.data;
                s_tuser <= drv_item.start;
                if (idle_mode != 0 && $urandom_range(0, gap_odds()) == 0)
                    src_gap <= $urandom_range(1, 16);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            snk_gap <= 0;
            long_left <= 0;
            long_used <= 1'b0;
        end
        else if (want_long_stall && !long_used)
        begin
            long_used <= 1'b1;
            long_left <= LONG_HOLD;
            m_tready <= 1'b0;
        end
        else if (long_left != 0)
        begin
            long_left <= long_left - 1;
            m_tready <= 1'b0;
        end
        else if (snk_gap != 0)
        begin
            snk_gap <= snk_gap - 1;
            m_tready <= 1'b0;
        end
        else if (idle_mode != 0 && $urandom_range(0, gap_odds()) == 0)
        begin
            snk_gap <= $urandom_range(0, 15);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // monitor: predict on input transactions, check output transactions
    always @(posedge clk)
    begin
        wr_cmd_t cmd;
        wr_cmd_t got;
        wr_cmd_t exp_cmd;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                bytes_taken++;
                if (decode_byte(s_tdata, s_tuser, cmd))
                    pending_writes.push_back(cmd);
            end
            if (m_tvalid && m_tready)
            begin
                got.addr = m_tdata[21:0];
                got.value = m_tdata[29:22];
                got.len = m_tdata[36:30];
                got.done = m_tlast;
                writes_seen++;
                if (got.done)
                    frames_seen++;
                if (pending_writes.size() == 0)
                begin
                    $display("%0t: unexpected write addr %h value %h len %0d done %b",
                             $time, got.addr, got.value, got.len, got.done);
                    err_cnt++;
                end
                else
                begin
                    exp_cmd = pending_writes.pop_front();
                    if (got.addr !== exp_cmd.addr)
                    begin
                        $display("%0t: pixel_address expected %h actual %h",
                                 $time, exp_cmd.addr, got.addr);
                        err_cnt++;
                    end
                    if (got.value !== exp_cmd.value)
                    begin
                        $display("%0t: pixel_value expected %h actual %h",
                                 $time, exp_cmd.value, got.value);
                        err_cnt++;
                    end
                    if (got.len !== exp_cmd.len)
                    begin
                        $display("%0t: run_length expected %0d actual %0d",
                                 $time, exp_cmd.len, got.len);
                        err_cnt++;
                    end
                    if (got.done !== exp_cmd.done)
                    begin
                        $display("%0t: frame_done expected %b actual %b",
                                 $time, exp_cmd.done, got.done);
                        err_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_CAP)
        begin
            $display("%0t: timeout with %0d writes outstanding", $time, pending_writes.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int fw;
        int fh;
        int bw;
        int pick;
        int lines;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bytes while idle are dropped
        idle_mode = 1;
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        drain();

        set_geometry(4, 2, 5);
        queue_byte(8'h12, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'h03, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h34, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFE, 1'b0);
        queue_byte(8'h11, 1'b0);
        queue_byte(8'h22, 1'b0);
        queue_byte(8'h80, 1'b1);
        queue_byte(8'h02, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'h81, 1'b0);
        drain();

        set_geometry(4, 0, 5);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'h05, 1'b0);
        queue_byte(8'h06, 1'b0);
        drain();

        set_geometry(0, 3, 7);
        queue_byte(8'h09, 1'b1);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h02, 1'b0);
        queue_byte(8'h03, 1'b0);
        drain();

        set_geometry(2047, 1, 2047);
        queue_frame(2047, 1);
        drain();

        // tallest frame, cut short by a restart
        set_geometry(1, 2047, 2047);
        queue_frame(1, 6);
        queue_frame(1, 3);
        drain();

        set_geometry(3, 3, 0);
        queue_frame(3, 3);
        drain();

        set_geometry(8, 4, 10);
        queue_frame(8, 2);
        drain();
        write_reg(CFG_BITMAP_WIDTH, CFG_W'(33));
        cfg_sets++;
        queue_line(8, 1'b0);
        queue_line(8, 1'b0);
        drain();

        // hold the output while input keeps coming
        idle_mode = 0;
        set_geometry(12, 5, 13);
        want_long_stall = 1'b1;
        repeat (3) queue_frame(12, 5);
        drain();

        while (items_sent < 1300)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                fw = 0;
            else if (pick == 1)
                fw = 1;
            else if (pick == 2)
                fw = $urandom_range(200, 2047);
            else
                fw = $urandom_range(1, 40);
            pick = $urandom_range(0, 19);
            if (pick == 0)
                fh = 0;
            else if (fw > 64)
                fh = 1;
            else
                fh = $urandom_range(1, 6);
            pick = $urandom_range(0, 9);
            bw = (pick == 0) ? 0 : ((pick == 1) ? 2047 : $urandom_range(0, 2047));
            set_geometry(fw, fh, bw);
            idle_mode = $urandom_range(0, 2);
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(5, 20))
                        queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                lines = (fh != 0 && $urandom_range(0, 3) == 0) ? $urandom_range(1, fh) : fh;
                queue_frame(fw, (lines == 0) ? 1 : lines);
            end
            drain();
        end

        // tail without idling
        idle_mode = 0;
        set_geometry(20, 3, 24);
        do
            queue_frame(20, 3);
        while (items_sent < 1400);

        while (chunk_bytes.size() != 0 || s_tvalid || pending_writes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Decoded %0d chunk bytes into %0d write commands, %0d frames completed",
                 bytes_taken, writes_seen, frames_seen);
        $display("Used %0d geometry settings incl. zero, one and full-scale sizes, %0d errors",
                 cfg_sets, err_cnt);
        if (err_cnt == 0 && pending_writes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ flic_byte_run_decode_core.f @@
+incdir+design
design/flic_brun_pkg.sv
design/flic_brun_cfg.sv
design/flic_brun_step.sv
design/flic_byte_run_decode_core.sv
tb/sv/flic_byte_run_decode_core_tb.sv
